/* rtl/triangle_classify_area_defines.svh */
// ----------------------------------------------------------------------------
// triangle_classify_area_defines
// assertion macros for the triangle classifier top-level rtl
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_CLASSIFY_AREA_DEFINES_SVH
`define TRIANGLE_CLASSIFY_AREA_DEFINES_SVH

// same-cycle implication, gated by reset
`define TCA_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, gated by reset
`define TCA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/tca_pkg.sv */
// ----------------------------------------------------------------------------
// tca_pkg
// shared widths, codes and the side-band tag of the triangle classifier
// ----------------------------------------------------------------------------
package tca_pkg;

    localparam int LEN_W    = 12;
    localparam int MARGIN_W = 12;
    localparam int PERIM_W  = 14;
    localparam int AREA_W   = 25;

    localparam logic [MARGIN_W-1:0] MARGIN_RESET = 12'd1;
    localparam logic [AREA_W-1:0]   AREA_MAX     = '1;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_ZERO = 2'd1,
        ST_INEQ = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        SH_SCALENE     = 2'd0,
        SH_ISOSCELES   = 2'd1,
        SH_EQUILATERAL = 2'd2
    } shape_t;

    typedef struct packed {
        status_t              status;
        shape_t               shape;
        logic [PERIM_W-1:0]   perim;
    } tca_tag_t;

endpackage

/* rtl/tca_check.sv */
// ----------------------------------------------------------------------------
// tca_check
// two stages: side checks and Heron factors, then status, class and the
// two partial products of 16*A^2
// ----------------------------------------------------------------------------
module tca_check #(
    parameter int SIDE_W = 12
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [tca_pkg::MARGIN_W-1:0] equal_margin,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [tca_pkg::LEN_W-1:0]    length_a,
    input  logic [tca_pkg::LEN_W-1:0]    length_b,
    input  logic [tca_pkg::LEN_W-1:0]    length_c,
    output logic                         dn_valid,
    input  logic                         dn_ready,
    output tca_pkg::tca_tag_t            dn_tag,
    output logic [2*(SIDE_W+2)-1:0]      dn_m1,
    output logic [2*(SIDE_W+2)-1:0]      dn_m2
);
    import tca_pkg::*;

    localparam int PW = SIDE_W + 2;
    localparam int MW = 2 * PW;

    logic [SIDE_W-1:0] a, b, c;
    logic [PW-1:0]     p_next;
    logic [PW:0]       fa_next, fb_next, fc_next;
    logic              zero_next;
    logic [2:0]        eq_next;
    logic [SIDE_W-1:0] dab, dbc, dac;

    logic              v1_reg;
    logic [PW-1:0]     p1_reg;
    logic [PW:0]       fa1_reg, fb1_reg, fc1_reg;
    logic              zero1_reg;
    logic [2:0]        eq1_reg;

    logic              bad;
    logic              ok;
    logic [PW-1:0]     fa, fb, fc;
    tca_tag_t          tag_next;
    logic [MW-1:0]     m1_next, m2_next;

    logic              v2_reg;
    tca_tag_t          tag2_reg;
    logic [MW-1:0]     m1_reg, m2_reg;

    logic              rdy1, rdy2;

    assign rdy2     = ~v2_reg | dn_ready;
    assign rdy1     = ~v1_reg | rdy2;
    assign in_ready = rdy1;

    // stage 1
    always_comb
    begin
        a = length_a[SIDE_W-1:0];
        b = length_b[SIDE_W-1:0];
        c = length_c[SIDE_W-1:0];
        p_next  = PW'(a) + PW'(b) + PW'(c);
        fa_next = (PW+1)'(p_next) - (PW+1)'({a, 1'b0});
        fb_next = (PW+1)'(p_next) - (PW+1)'({b, 1'b0});
        fc_next = (PW+1)'(p_next) - (PW+1)'({c, 1'b0});
        zero_next = (a == '0) || (b == '0) || (c == '0);
        dab = (a > b) ? (a - b) : (b - a);
        dbc = (b > c) ? (b - c) : (c - b);
        dac = (a > c) ? (a - c) : (c - a);
        eq_next[0] = MARGIN_W'(dab) < equal_margin;
        eq_next[1] = MARGIN_W'(dbc) < equal_margin;
        eq_next[2] = MARGIN_W'(dac) < equal_margin;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (rdy1)
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            p1_reg    <= p_next;
            fa1_reg   <= fa_next;
            fb1_reg   <= fb_next;
            fc1_reg   <= fc_next;
            zero1_reg <= zero_next;
            eq1_reg   <= eq_next;
        end
    end

    // stage 2
    always_comb
    begin
        // strict inequality fails when some p - 2x is not positive
        bad = fa1_reg[PW] || (fa1_reg == '0) ||
              fb1_reg[PW] || (fb1_reg == '0) ||
              fc1_reg[PW] || (fc1_reg == '0);
        ok  = !zero1_reg && !bad;

        tag_next.perim = PERIM_W'(p1_reg);
        priority if (zero1_reg)
        begin
            tag_next.status = ST_ZERO;
        end
        else if (bad)
        begin
            tag_next.status = ST_INEQ;
        end
        else
        begin
            tag_next.status = ST_OK;
        end

        priority if (!ok)
        begin
            tag_next.shape = SH_SCALENE;
        end
        else if (eq1_reg[0] && eq1_reg[1])
        begin
            tag_next.shape = SH_EQUILATERAL;
        end
        else if (|eq1_reg)
        begin
            tag_next.shape = SH_ISOSCELES;
        end
        else
        begin
            tag_next.shape = SH_SCALENE;
        end

        // invalid items carry a zero product so the root comes out zero
        fa = ok ? fa1_reg[PW-1:0] : '0;
        fb = ok ? fb1_reg[PW-1:0] : '0;
        fc = ok ? fc1_reg[PW-1:0] : '0;
        m1_next = MW'(p1_reg) * MW'(fa);
        m2_next = MW'(fb) * MW'(fc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (rdy2)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            tag2_reg <= tag_next;
            m1_reg   <= m1_next;
            m2_reg   <= m2_next;
        end
    end

    assign dn_valid = v2_reg;
    assign dn_tag   = tag2_reg;
    assign dn_m1    = m1_reg;
    assign dn_m2    = m2_reg;

endmodule

/* rtl/tca_mult.sv */
// ----------------------------------------------------------------------------
// tca_mult
// one stage: full product p(p-2a)(p-2b)(p-2c) from the two partials
// ----------------------------------------------------------------------------
module tca_mult #(
    parameter int SIDE_W = 12
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      up_valid,
    output logic                      up_ready,
    input  tca_pkg::tca_tag_t         up_tag,
    input  logic [2*(SIDE_W+2)-1:0]   up_m1,
    input  logic [2*(SIDE_W+2)-1:0]   up_m2,
    output logic                      dn_valid,
    input  logic                      dn_ready,
    output tca_pkg::tca_tag_t         dn_tag,
    output logic [4*(SIDE_W+2)-1:0]   dn_prod
);
    import tca_pkg::*;

    localparam int RW = 4 * (SIDE_W + 2);

    logic          v_reg;
    tca_tag_t      tag_reg;
    logic [RW-1:0] prod_reg;
    logic          rdy;

    assign rdy      = ~v_reg | dn_ready;
    assign up_ready = rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (rdy)
        begin
            v_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy)
        begin
            tag_reg  <= up_tag;
            prod_reg <= RW'(up_m1) * RW'(up_m2);
        end
    end

    assign dn_valid = v_reg;
    assign dn_tag   = tag_reg;
    assign dn_prod  = prod_reg;

endmodule

/* rtl/tca_sqrt.sv */
// ----------------------------------------------------------------------------
// tca_sqrt
// pipelined floor square root, one result bit per stage
// ----------------------------------------------------------------------------
module tca_sqrt #(
    parameter int SIDE_W = 12
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      up_valid,
    output logic                      up_ready,
    input  tca_pkg::tca_tag_t         up_tag,
    input  logic [4*(SIDE_W+2)-1:0]   up_prod,
    output logic                      dn_valid,
    input  logic                      dn_ready,
    output tca_pkg::tca_tag_t         dn_tag,
    output logic [2*(SIDE_W+2)-1:0]   dn_root
);
    import tca_pkg::*;

    localparam int R  = 2 * (SIDE_W + 2);
    localparam int RW = 2 * R;
    localparam int NS = R;

    logic [RW-1:0] rem_reg  [NS];
    logic [RW-1:0] root_reg [NS];
    tca_tag_t      tag_reg  [NS];
    logic [NS-1:0] v_reg;
    logic [NS-1:0] rdy;

    for (genvar k = 0; k < NS; k++)
    begin : g_stage
        localparam logic [RW-1:0] STEP_BIT = {{(RW-1){1'b0}}, 1'b1} << (2 * (R - 1 - k));

        logic [RW-1:0] rem_in, root_in, trial;
        logic [RW-1:0] rem_next, root_next;
        tca_tag_t      tag_in;
        logic          v_in;

        // a stage moves when it is empty or nothing downstream is blocked
        assign rdy[k] = dn_ready | ~(&v_reg[NS-1:k]);

        if (k == 0)
        begin : g_first
            assign rem_in  = up_prod;
            assign root_in = '0;
            assign tag_in  = up_tag;
            assign v_in    = up_valid;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign tag_in  = tag_reg[k-1];
            assign v_in    = v_reg[k-1];
        end

        always_comb
        begin
            trial = root_in + STEP_BIT;
            if (rem_in >= trial)
            begin
                rem_next  = rem_in - trial;
                root_next = (root_in >> 1) + STEP_BIT;
            end
            else
            begin
                rem_next  = rem_in;
                root_next = root_in >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (rdy[k])
            begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[k])
            begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                tag_reg[k]  <= tag_in;
            end
        end
    end

    assign up_ready = rdy[0];
    assign dn_valid = v_reg[NS-1];
    assign dn_tag   = tag_reg[NS-1];
    assign dn_root  = root_reg[NS-1][R-1:0];

endmodule

/* rtl/triangle_classify_area.sv */
// path: input passes the check stages, the multiply stage, the square-root stages and the output register
// throughput: one triangle per cycle while the output is not stalled, set by the one-bit-per-stage square-root pipeline
// a stalled output only holds back stages that are full; bubbles are filled
// reset: rst_n asynchronous, clears all valid bits and sets equal_margin to 1
// ----------------------------------------------------------------------------
// triangle_classify_area
// triangle status, shape class, perimeter and Heron area in quarter units
// ----------------------------------------------------------------------------
`include "triangle_classify_area_defines.svh"

module triangle_classify_area #(
    parameter int SIDE_BITS = 12
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [tca_pkg::MARGIN_W-1:0] cfg_wr_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [tca_pkg::LEN_W-1:0]    length_a,
    input  logic [tca_pkg::LEN_W-1:0]    length_b,
    input  logic [tca_pkg::LEN_W-1:0]    length_c,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [1:0]                   status,
    output logic [1:0]                   shape_class,
    output logic [tca_pkg::PERIM_W-1:0]  perimeter_sum,
    output logic [tca_pkg::AREA_W-1:0]   area_quarters
);
    import tca_pkg::*;

    localparam int SW = (SIDE_BITS < LEN_W) ? SIDE_BITS : LEN_W;
    localparam int PW = SW + 2;
    localparam int R  = 2 * PW;
    localparam int CW = (R > AREA_W) ? R : AREA_W;

    logic [MARGIN_W-1:0] equal_margin_reg;

    logic            chk_valid, chk_ready;
    tca_tag_t        chk_tag;
    logic [2*PW-1:0] chk_m1, chk_m2;

    logic            mul_valid, mul_ready;
    tca_tag_t        mul_tag;
    logic [4*PW-1:0] mul_prod;

    logic            sq_valid, sq_ready;
    tca_tag_t        sq_tag;
    logic [R-1:0]    sq_root;

    logic [AREA_W-1:0] area_next;
    logic              out_valid_reg;
    tca_tag_t          out_tag_reg;
    logic [AREA_W-1:0] area_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            equal_margin_reg <= MARGIN_RESET;
        end
        else if (cfg_wr_en)
        begin
            equal_margin_reg <= cfg_wr_data;
        end
    end

    tca_check #(
        .SIDE_W (SW)
    ) u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .equal_margin (equal_margin_reg),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .length_a     (length_a),
        .length_b     (length_b),
        .length_c     (length_c),
        .dn_valid     (chk_valid),
        .dn_ready     (chk_ready),
        .dn_tag       (chk_tag),
        .dn_m1        (chk_m1),
        .dn_m2        (chk_m2)
    );

    tca_mult #(
        .SIDE_W (SW)
    ) u_mult (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (chk_valid),
        .up_ready (chk_ready),
        .up_tag   (chk_tag),
        .up_m1    (chk_m1),
        .up_m2    (chk_m2),
        .dn_valid (mul_valid),
        .dn_ready (mul_ready),
        .dn_tag   (mul_tag),
        .dn_prod  (mul_prod)
    );

    tca_sqrt #(
        .SIDE_W (SW)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (mul_valid),
        .up_ready (mul_ready),
        .up_tag   (mul_tag),
        .up_prod  (mul_prod),
        .dn_valid (sq_valid),
        .dn_ready (sq_ready),
        .dn_tag   (sq_tag),
        .dn_root  (sq_root)
    );

    // output register with area saturation
    assign sq_ready = ~out_valid_reg | out_ready;

    always_comb
    begin
        if (CW'(sq_root) > CW'(AREA_MAX))
        begin
            area_next = AREA_MAX;
        end
        else
        begin
            area_next = AREA_W'(sq_root);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (sq_ready)
        begin
            out_valid_reg <= sq_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sq_ready)
        begin
            out_tag_reg <= sq_tag;
            area_reg    <= area_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_tag_reg.status;
    assign shape_class   = out_tag_reg.shape;
    assign perimeter_sum = out_tag_reg.perim;
    assign area_quarters = area_reg;

    `TCA_ASSERT_SAME(a_invalid_clean, clk, rst_n,
        out_valid && (status != ST_OK),
        (area_quarters == '0) && (shape_class == SH_SCALENE),
        "invalid triangle with area or class")
    `TCA_ASSERT_SAME(a_valid_area, clk, rst_n,
        out_valid && (status == ST_OK), area_quarters != '0,
        "valid triangle with zero area")
    `TCA_ASSERT_SAME(a_no_idle_stall, clk, rst_n,
        !out_valid || out_ready, in_ready,
        "input stalled while output free")
    `TCA_ASSERT_NEXT(a_margin_write, clk, rst_n,
        cfg_wr_en, equal_margin_reg == $past(cfg_wr_data),
        "margin write lost")

endmodule
